### rtl/lpmd_pkg.sv
// Shared types and constants for the length-prefixed message deframer.
package lpmd_pkg;

	// Field widths
	localparam int LEN_W   = 17;
	localparam int LAT_W   = 54;
	localparam int TOT_M_W = 32;
	localparam int TOT_B_W = 48;
	localparam int TOT_L_W = 64;

	// Defaults for top-level parameters
	localparam int HOLD_BYTES_DEF = 11;
	localparam int FIFO_DEPTH_DEF = 4;

	// Frame format
	localparam logic [LEN_W-1:0] MAGIC_POS   = 17'd10;
	localparam logic [7:0]       MAGIC_VALUE = 8'hFF;
	localparam logic [LEN_W-1:0] MIN_LEN     = 17'd16;
	localparam logic [LEN_W-1:0] LEN_BIAS    = 17'd2;
	localparam logic [LEN_W-1:0] MAX_LEN_RST = 17'd4096;
	localparam logic signed [20:0] USEC_PER_SEC = 21'sd1000000;

	// Front-end parse mode
	typedef enum logic [1:0] {
		MODE_HEADER  = 2'd0,
		MODE_PASS    = 2'd1,
		MODE_SWALLOW = 2'd2
	} mode_t;

	// Command passed from front to back
	typedef enum logic [1:0] {
		CMD_BYTE      = 2'd0,
		CMD_RELEASE   = 2'd1,
		CMD_BAD_MAGIC = 2'd2,
		CMD_TOO_SHORT = 2'd3
	} cmd_t;

	// Result word kind
	typedef enum logic [1:0] {
		KIND_GOOD      = 2'd0,
		KIND_BAD_MAGIC = 2'd1,
		KIND_TOO_SHORT = 2'd2
	} kind_t;

	// Queue entry
	typedef struct packed {
		cmd_t                    cmd;
		logic [7:0]              data;
		logic                    last;
		logic signed [LAT_W-1:0] lat;
	} qcmd_t;

endpackage

### rtl/length_prefixed_message_deframer.sv
// A pass-through word reaches the output through the queue and then the output register.
// Throughput: one input word per cycle, held header bytes drain one per cycle; a full queue or low out_ready stalls.
// A new message's header is not taken until the back end has picked up the last release.
// Queue depth FIFO_DEPTH decouples front and back; output register decouples the consumer.
// Reset (arst_n, async): framing, queue, totals cleared; max length 4096; no clearing pass.
module length_prefixed_message_deframer import lpmd_pkg::*; #(
	parameter int HEADER_HOLD_BYTES = HOLD_BYTES_DEF,
	parameter int FIFO_DEPTH        = FIFO_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input stream
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic [31:0]                now_seconds,
	// config write
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [LEN_W-1:0]           cfg_data,
	// result stream
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic [1:0]                 out_kind,
	output logic                       first_of_message,
	output logic                       last_of_message,
	output logic [TOT_M_W-1:0]         messages_total,
	output logic [TOT_B_W-1:0]         bytes_total,
	output logic signed [TOT_L_W-1:0]  latency_sum_us
);

	logic                                push_valid;
	qcmd_t                               push_entry;
	logic                                q_full;
	logic                                pop;
	logic                                head_valid;
	qcmd_t                               head_entry;
	logic [HEADER_HOLD_BYTES-1:0][7:0]   hold_bytes;
	logic                                rel_taken;

	assign cfg_ready = 1'b1;

	lpmd_front #(
		.HOLD (HEADER_HOLD_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.now_seconds (now_seconds),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.push_valid  (push_valid),
		.push_entry  (push_entry),
		.q_full      (q_full),
		.hold_bytes  (hold_bytes),
		.rel_taken   (rel_taken)
	);

	lpmd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	lpmd_back #(
		.HOLD (HEADER_HOLD_BYTES)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_valid       (head_valid),
		.head_entry       (head_entry),
		.pop              (pop),
		.hold_bytes       (hold_bytes),
		.rel_taken        (rel_taken),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_byte         (out_byte),
		.out_kind         (out_kind),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.messages_total   (messages_total),
		.bytes_total      (bytes_total),
		.latency_sum_us   (latency_sum_us)
	);

endmodule

### rtl/lpmd_front.sv
// Front end: accepts stream words, tracks framing, holds header bytes, issues commands.
module lpmd_front import lpmd_pkg::*; #(
	parameter int HOLD = HOLD_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// stream input
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               data_byte,
	input  logic [31:0]              now_seconds,
	// config write
	input  logic                     cfg_valid,
	input  logic [LEN_W-1:0]         cfg_data,
	// queue push
	output logic                     push_valid,
	output qcmd_t                    push_entry,
	input  logic                     q_full,
	// header bytes for the back end, and release pickup
	output logic [HOLD-1:0][7:0]     hold_bytes,
	input  logic                     rel_taken
);

	localparam int HIDX_W = $clog2(HOLD);
	localparam logic [LEN_W-1:0] HOLD_LAST = LEN_W'(HOLD - 1);
	localparam logic [LEN_W-1:0] HOLD_LEN  = LEN_W'(HOLD);

	mode_t                 mode_q, mode_d;
	logic [LEN_W-1:0]      pos_q, pos_d;
	logic [LEN_W-1:0]      len_q, len_d;
	logic [LEN_W-1:0]      max_len_q;
	logic [31:0]           send_q;
	logic [HOLD-1:0][7:0]  hold_q;
	logic                  rel_pend_q;

	logic                  accept;
	logic                  hdr;
	logic                  pos_is1;
	logic [LEN_W-1:0]      pos_inc;
	logic [LEN_W-1:0]      len_calc;
	logic [LEN_W-1:0]      len_cur;
	logic                  too_short;
	logic                  too_long;
	logic signed [32:0]    diff;
	logic signed [LAT_W-1:0] lat_prod;

	assign hdr      = (mode_q == MODE_HEADER);
	assign in_ready = !q_full && !(rel_pend_q && hdr);
	assign accept   = in_valid && in_ready;

	// Length decode at byte 1
	assign pos_is1   = (pos_q == 17'd1);
	assign pos_inc   = pos_q + 17'd1;
	assign len_calc  = {1'b0, hold_q[0], data_byte} + LEN_BIAS;
	assign len_cur   = pos_is1 ? len_calc : len_q;
	assign too_short = pos_is1 && (len_calc < MIN_LEN);
	assign too_long  = pos_is1 && !too_short && (len_calc > max_len_q);

	// Latency of this message in microseconds
	assign diff     = $signed({1'b0, now_seconds}) - $signed({1'b0, send_q});
	assign lat_prod = diff * USEC_PER_SEC;

	assign hold_bytes = hold_q;

	// Classify the word and pick the next mode and position
	always_comb begin
		mode_d          = mode_q;
		pos_d           = pos_q;
		len_d           = len_q;
		push_valid      = 1'b0;
		push_entry.cmd  = CMD_BYTE;
		push_entry.data = data_byte;
		push_entry.last = 1'b0;
		push_entry.lat  = lat_prod;
		if (accept) begin
			len_d = len_cur;
			case (mode_q)
				MODE_HEADER: begin
					if (too_short) begin
						push_valid     = 1'b1;
						push_entry.cmd = CMD_TOO_SHORT;
						mode_d         = MODE_SWALLOW;
					end else if (too_long) begin
						mode_d = MODE_SWALLOW;
					end else if (pos_q == MAGIC_POS && data_byte != MAGIC_VALUE) begin
						push_valid     = 1'b1;
						push_entry.cmd = CMD_BAD_MAGIC;
						mode_d         = MODE_SWALLOW;
					end else if (pos_q == HOLD_LAST) begin
						push_valid      = 1'b1;
						push_entry.cmd  = CMD_RELEASE;
						push_entry.last = (len_cur == HOLD_LEN);
						mode_d          = MODE_PASS;
					end
				end
				MODE_PASS: begin
					push_valid      = 1'b1;
					push_entry.cmd  = CMD_BYTE;
					push_entry.last = (pos_inc == len_cur);
				end
				default: begin
				end
			endcase
			// end of message
			if (pos_q != '0 && pos_inc >= len_cur) begin
				pos_d  = '0;
				mode_d = MODE_HEADER;
			end else begin
				pos_d = pos_inc;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_HEADER;
			pos_q      <= '0;
			len_q      <= '0;
			send_q     <= '0;
			max_len_q  <= MAX_LEN_RST;
			rel_pend_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			len_q  <= len_d;
			if (accept && hdr && pos_q >= 17'd2 && pos_q <= 17'd5) begin
				send_q <= {send_q[23:0], data_byte};
			end
			if (cfg_valid) begin
				max_len_q <= cfg_data;
			end
			if (push_valid && push_entry.cmd == CMD_RELEASE) begin
				rel_pend_q <= 1'b1;
			end else if (rel_taken) begin
				rel_pend_q <= 1'b0;
			end
		end
	end

	// Header hold bytes
	always_ff @(posedge clk) begin
		if (accept && hdr && pos_q < HOLD_LEN) begin
			hold_q[pos_q[HIDX_W-1:0]] <= data_byte;
		end
	end

endmodule

### rtl/lpmd_fifo.sv
// Command queue between the front and back ends.
module lpmd_fifo import lpmd_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  qcmd_t push_entry,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output qcmd_t head_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	qcmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push_valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// front must not push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (count_q != CNT_FULL) || do_pop)
		else $error("push into full command queue");

endmodule

### rtl/lpmd_back.sv
// Back end: executes queued commands, drains held header bytes, keeps totals.
module lpmd_back import lpmd_pkg::*; #(
	parameter int HOLD = HOLD_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// queue head
	input  logic                        head_valid,
	input  qcmd_t                       head_entry,
	output logic                        pop,
	// header bytes from the front end
	input  logic [HOLD-1:0][7:0]        hold_bytes,
	output logic                        rel_taken,
	// result output
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic [1:0]                  out_kind,
	output logic                        first_of_message,
	output logic                        last_of_message,
	output logic [TOT_M_W-1:0]          messages_total,
	output logic [TOT_B_W-1:0]          bytes_total,
	output logic signed [TOT_L_W-1:0]   latency_sum_us
);

	localparam int HIDX_W = $clog2(HOLD);
	localparam logic [HIDX_W-1:0] IDX_LAST = HIDX_W'(HOLD - 1);

	// drain state
	logic                    draining_q;
	logic [HIDX_W-1:0]       drain_idx_q;
	logic [HOLD-1:0][7:0]    drain_q;
	logic                    drain_last_q;
	logic signed [LAT_W-1:0] drain_lat_q;

	// running totals
	logic [TOT_M_W-1:0]         msg_cnt_q;
	logic [TOT_B_W-1:0]         byte_cnt_q;
	logic signed [TOT_L_W-1:0]  lat_acc_q;

	// output register
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	kind_t                      out_kind_q;
	logic                       out_first_q;
	logic                       out_last_q;
	logic [TOT_M_W-1:0]         out_msgs_q;
	logic [TOT_B_W-1:0]         out_bytes_q;
	logic signed [TOT_L_W-1:0]  out_lat_q;

	logic                       can_emit;
	logic                       em_valid;
	logic                       fire;
	logic [7:0]                 em_byte;
	kind_t                      em_kind;
	logic                       em_first;
	logic                       em_last;
	logic                       em_good;
	logic signed [LAT_W-1:0]    em_lat;
	logic [TOT_M_W-1:0]         msg_cnt_n;
	logic [TOT_B_W-1:0]         byte_cnt_n;
	logic signed [TOT_L_W-1:0]  lat_acc_n;

	assign can_emit  = !out_valid_q || out_ready;
	assign em_valid  = draining_q || head_valid;
	assign fire      = can_emit && em_valid;
	assign pop       = can_emit && !draining_q && head_valid;
	assign rel_taken = pop && (head_entry.cmd == CMD_RELEASE);

	// Select the next result word
	always_comb begin
		em_byte  = drain_q[drain_idx_q];
		em_kind  = KIND_GOOD;
		em_first = 1'b0;
		em_last  = (drain_idx_q == IDX_LAST) && drain_last_q;
		em_good  = 1'b1;
		em_lat   = drain_lat_q;
		if (!draining_q) begin
			em_lat = head_entry.lat;
			case (head_entry.cmd)
				CMD_BYTE: begin
					em_byte = head_entry.data;
					em_last = head_entry.last;
				end
				CMD_RELEASE: begin
					em_byte  = hold_bytes[0];
					em_first = 1'b1;
					em_last  = 1'b0;
				end
				CMD_BAD_MAGIC: begin
					em_byte  = '0;
					em_kind  = KIND_BAD_MAGIC;
					em_first = 1'b1;
					em_last  = 1'b1;
					em_good  = 1'b0;
				end
				CMD_TOO_SHORT: begin
					em_byte  = '0;
					em_kind  = KIND_TOO_SHORT;
					em_first = 1'b1;
					em_last  = 1'b1;
					em_good  = 1'b0;
				end
				default: begin
					em_good = 1'b0;
				end
			endcase
		end
	end

	// Totals after this word
	assign byte_cnt_n = byte_cnt_q + 1'b1;
	assign msg_cnt_n  = msg_cnt_q + 1'b1;
	assign lat_acc_n  = lat_acc_q + TOT_L_W'(em_lat);

	// Control and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q  <= 1'b0;
			drain_idx_q <= '0;
			msg_cnt_q   <= '0;
			byte_cnt_q  <= '0;
			lat_acc_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_emit) begin
				out_valid_q <= em_valid;
			end
			if (rel_taken) begin
				draining_q  <= 1'b1;
				drain_idx_q <= HIDX_W'(1);
			end else if (fire && draining_q) begin
				if (drain_idx_q == IDX_LAST) begin
					draining_q <= 1'b0;
				end
				drain_idx_q <= drain_idx_q + 1'b1;
			end
			if (fire && em_good) begin
				byte_cnt_q <= byte_cnt_n;
				if (em_last) begin
					msg_cnt_q <= msg_cnt_n;
					lat_acc_q <= lat_acc_n;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (rel_taken) begin
			drain_q      <= hold_bytes;
			drain_last_q <= head_entry.last;
			drain_lat_q  <= head_entry.lat;
		end
		if (fire) begin
			out_byte_q  <= em_byte;
			out_kind_q  <= em_kind;
			out_first_q <= em_first;
			out_last_q  <= em_last;
			if (em_good && em_last) begin
				out_msgs_q  <= msg_cnt_n;
				out_bytes_q <= byte_cnt_n;
				out_lat_q   <= lat_acc_n;
			end else begin
				out_msgs_q  <= '0;
				out_bytes_q <= '0;
				out_lat_q   <= '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign out_byte         = out_byte_q;
	assign out_kind         = out_kind_q;
	assign first_of_message = out_first_q;
	assign last_of_message  = out_last_q;
	assign messages_total   = out_msgs_q;
	assign bytes_total      = out_bytes_q;
	assign latency_sum_us   = out_lat_q;

	// byte zero goes out on pickup, so the drain index starts past it
	a_drain_idx: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> drain_idx_q != '0)
		else $error("drain index at zero while draining");

	// a release pickup starts a drain on the next cycle
	a_rel_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rel_taken |=> draining_q)
		else $error("release taken without drain");

	// totals only show on a last word
	a_totals_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |->
		(out_msgs_q == '0 && out_bytes_q == '0 && out_lat_q == '0))
		else $error("totals on a non-final word");

	// notices are single-word messages
	a_notice_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q != KIND_GOOD) |-> (out_first_q && out_last_q))
		else $error("notice without first/last flags");

endmodule
